/* rtl/lsfb_pkg.sv */
// shared widths, constants and stage payload types of the seam feather blend
package lsfb_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned NUM_CH    = 3;
  localparam int unsigned COL_W     = 12;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned ACC_W     = 20;
  localparam int unsigned QUO_W     = 8;
  localparam int unsigned MAX_WIDTH = 4096;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ADDR_W    = 3;

  localparam logic REG_OVERLAP_START = 1'b0;
  localparam logic REG_IMAGE_WIDTH   = 1'b1;

  typedef logic [NUM_CH-1:0][PIX_W-1:0] lsfb_px_t;

  typedef struct packed {
    logic [CFG_W-1:0] overlap_start_raw;
    logic [CFG_W-1:0] image_width;
  } lsfb_cfg_t;

  typedef struct packed {
    logic             in_range;
    logic             black;
    lsfb_px_t         first_px;
    lsfb_px_t         second_px;
    logic [COL_W-1:0] k;
    logic [CFG_W-1:0] wmk;
    logic [CFG_W-1:0] w;
  } lsfb_setup_t;

  typedef struct packed {
    logic                         in_range;
    logic                         black;
    lsfb_px_t                     first_px;
    logic [CFG_W-1:0]             w;
    logic [NUM_CH-1:0][ACC_W-1:0] rem;
    logic [NUM_CH-1:0][QUO_W-1:0] quo;
  } lsfb_div_t;

endpackage

/* rtl/lsfb_in_if.sv */
// input channel: column and the two source pixels
interface lsfb_in_if;
  import lsfb_pkg::*;

  logic             valid;
  logic             ready;
  logic [COL_W-1:0] column;
  logic [PIX_W-1:0] first_c0;
  logic [PIX_W-1:0] first_c1;
  logic [PIX_W-1:0] first_c2;
  logic [PIX_W-1:0] second_c0;
  logic [PIX_W-1:0] second_c1;
  logic [PIX_W-1:0] second_c2;

  modport source (
    output valid, column, first_c0, first_c1, first_c2, second_c0, second_c1, second_c2,
    input  ready
  );

  modport sink (
    input  valid, column, first_c0, first_c1, first_c2, second_c0, second_c1, second_c2,
    output ready
  );
endinterface

/* rtl/lsfb_out_if.sv */
// output channel: blended pixel and write enable
interface lsfb_out_if;
  import lsfb_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] blend_c0;
  logic [PIX_W-1:0] blend_c1;
  logic [PIX_W-1:0] blend_c2;
  logic             write_enable;

  modport source (
    output valid, blend_c0, blend_c1, blend_c2, write_enable,
    input  ready
  );

  modport sink (
    input  valid, blend_c0, blend_c1, blend_c2, write_enable,
    output ready
  );
endinterface

/* rtl/linear_seam_feather_blend.sv */
// top level of the linear seam feather blend pipeline
//
// in_i carries one item per pixel: column index, reference pixel and warped
// pixel. out_o returns exactly one item per input item, in order: three
// blended channels and write_enable, which is high when the column lies in
// [max(overlap_start_raw, 0), image_width). Outside that range the channels
// are zero; a black warped pixel passes the reference pixel through.
// The APB port holds overlap_start_raw at address 0 and image_width at
// address 4; write them only while no item is in flight.
// Throughput is one item per clock while out_o.ready stays high. From acceptance
// to out_o.valid an item passes one setup stage, one multiply-add stage, eight
// restoring division steps (one quotient bit each) and the output register.
// When the receiver holds out_o.ready low, each stage keeps its item and
// empty stages further up still fill, so in_i.ready drops only once the
// whole pipeline is full. Reset empties the pipeline and loads start 0 and
// width 4096.
module linear_seam_feather_blend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  lsfb_in_if.sink                       in_i,
  lsfb_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lsfb_pkg::ADDR_W-1:0]   paddr,
  input  logic [lsfb_pkg::DATA_W-1:0]   pwdata,
  output logic [lsfb_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import lsfb_pkg::*;

  localparam int unsigned NUM_STAGES = QUO_W + 3;

  lsfb_cfg_t              cfg_q;
  logic                   cfg_we;
  logic [NUM_STAGES-1:0]  valid_q;
  logic [NUM_STAGES-1:0]  valid_d;
  logic [NUM_STAGES-1:0]  en;
  lsfb_px_t               first_px;
  lsfb_px_t               second_px;
  lsfb_setup_t            setup;
  lsfb_div_t              div_chain [QUO_W+1];
  lsfb_div_t              last;
  logic [PIX_W-1:0]       blend_q [NUM_CH];
  logic [PIX_W-1:0]       blend_d [NUM_CH];
  logic                   we_q;
  logic                   we_d;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overlap_start_raw <= '0;
      cfg_q.image_width       <= CFG_W'(4096);
    end else if (cfg_we) begin
      case (paddr[2])
        REG_OVERLAP_START: cfg_q.overlap_start_raw <= pwdata[CFG_W-1:0];
        REG_IMAGE_WIDTH:   cfg_q.image_width       <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_OVERLAP_START: prdata = DATA_W'(cfg_q.overlap_start_raw);
      REG_IMAGE_WIDTH:   prdata = DATA_W'(cfg_q.image_width);
      default:           prdata = '0;
    endcase
  end

  // stage enables: a stage loads when it is empty or its item moves on
  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_o.ready;
    for (int s = NUM_STAGES - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
    valid_d[0] = in_i.valid;
    for (int s = 1; s < NUM_STAGES; s++) begin
      valid_d[s] = valid_q[s-1];
    end
  end

  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NUM_STAGES; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_d[s];
        end
      end
    end
  end

  assign first_px  = {in_i.first_c2, in_i.first_c1, in_i.first_c0};
  assign second_px = {in_i.second_c2, in_i.second_c1, in_i.second_c0};

  lsfb_front u_front (
    .clk_i    (clk_i),
    .en_i     (en[0]),
    .cfg_i    (cfg_q),
    .column_i (in_i.column),
    .first_i  (first_px),
    .second_i (second_px),
    .setup_o  (setup)
  );

  lsfb_mac u_mac (
    .clk_i   (clk_i),
    .en_i    (en[1]),
    .setup_i (setup),
    .div_o   (div_chain[0])
  );

  for (genvar i = 0; i < QUO_W; i++) begin : g_div
    lsfb_div_step #(
      .STEP_BIT (QUO_W - 1 - i)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en[i+2]),
      .div_i (div_chain[i]),
      .div_o (div_chain[i+1])
    );
  end

  assign last = div_chain[QUO_W];

  // output register
  always_comb begin
    we_d = last.in_range;
    for (int c = 0; c < NUM_CH; c++) begin
      if (!last.in_range) begin
        blend_d[c] = '0;
      end else if (last.black) begin
        blend_d[c] = last.first_px[c];
      end else begin
        blend_d[c] = last.quo[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NUM_STAGES-1]) begin
      we_q <= we_d;
      for (int c = 0; c < NUM_CH; c++) begin
        blend_q[c] <= blend_d[c];
      end
    end
  end

  assign out_o.valid        = valid_q[NUM_STAGES-1];
  assign out_o.blend_c0     = blend_q[0];
  assign out_o.blend_c1     = blend_q[1];
  assign out_o.blend_c2     = blend_q[2];
  assign out_o.write_enable = we_q;
endmodule

/* rtl/lsfb_front.sv */
// first stage: overlap bounds, column offset and black pixel test
module lsfb_front (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  lsfb_pkg::lsfb_cfg_t                 cfg_i,
  input  logic [lsfb_pkg::COL_W-1:0]          column_i,
  input  lsfb_pkg::lsfb_px_t                  first_i,
  input  lsfb_pkg::lsfb_px_t                  second_i,
  output lsfb_pkg::lsfb_setup_t               setup_o
);
  import lsfb_pkg::*;

  logic [COL_W-1:0] start;
  logic [CFG_W-1:0] width_sat;
  lsfb_setup_t      setup_d;
  lsfb_setup_t      setup_q;

  always_comb begin
    start     = cfg_i.overlap_start_raw[CFG_W-1] ? '0 : cfg_i.overlap_start_raw[COL_W-1:0];
    width_sat = (cfg_i.image_width > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : cfg_i.image_width;

    setup_d.in_range  = (column_i >= start) && ({1'b0, column_i} < width_sat);
    setup_d.black     = (second_i == '0);
    setup_d.first_px  = first_i;
    setup_d.second_px = second_i;
    setup_d.k         = column_i - start;
    setup_d.wmk       = width_sat - {1'b0, column_i};
    setup_d.w         = width_sat - {1'b0, start};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      setup_q <= setup_d;
    end
  end

  assign setup_o = setup_q;
endmodule

/* rtl/lsfb_mac.sv */
// second stage: weighted sum of the two pixels per channel
module lsfb_mac (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  lsfb_pkg::lsfb_setup_t setup_i,
  output lsfb_pkg::lsfb_div_t   div_o
);
  import lsfb_pkg::*;

  lsfb_div_t div_d;
  lsfb_div_t div_q;

  always_comb begin
    div_d.in_range = setup_i.in_range;
    div_d.black    = setup_i.black;
    div_d.first_px = setup_i.first_px;
    div_d.w        = setup_i.w;
    div_d.quo      = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      div_d.rem[c] = ACC_W'(setup_i.first_px[c]) * ACC_W'(setup_i.wmk)
                   + ACC_W'(setup_i.second_px[c]) * ACC_W'(setup_i.k);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;
endmodule

/* rtl/lsfb_div_step.sv */
// one restoring division step, one quotient bit for each channel
module lsfb_div_step #(
  parameter int unsigned STEP_BIT = 7
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  lsfb_pkg::lsfb_div_t div_i,
  output lsfb_pkg::lsfb_div_t div_o
);
  import lsfb_pkg::*;

  localparam int unsigned DVS_W = ACC_W + 1;

  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] diff;
  lsfb_div_t        div_d;
  lsfb_div_t        div_q;

  always_comb begin
    dvs   = DVS_W'(div_i.w) << STEP_BIT;
    div_d = div_i;
    diff  = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      diff = {1'b0, div_i.rem[c]} - dvs;
      if ({1'b0, div_i.rem[c]} >= dvs) begin
        div_d.rem[c]           = diff[ACC_W-1:0];
        div_d.quo[c][STEP_BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign div_o = div_q;
endmodule

/* tb/tb_linear_seam_feather_blend.sv */
`timescale 1ns / 1ps
// testbench for the seam feather blend: directed table, then random pixel streams vs a predictor
module tb_linear_seam_feather_blend;
  import lsfb_pkg::*;

  localparam int unsigned PIPE_LATENCY   = 11;
  localparam int unsigned HOLD_CYCLES    = 80;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 105;
  localparam int unsigned NUM_PHASES     = 8;

  localparam logic [ADDR_W-1:0] ADDR_OVERLAP_START = ADDR_W'(4 * REG_OVERLAP_START);
  localparam logic [ADDR_W-1:0] ADDR_IMAGE_WIDTH   = ADDR_W'(4 * REG_IMAGE_WIDTH);

  typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

  typedef struct packed {
    logic [COL_W-1:0] column;
    lsfb_px_t         first_px;
    lsfb_px_t         second_px;
  } pixel_item_t;

  typedef struct packed {
    lsfb_px_t blend;
    logic     write_enable;
  } blend_res_t;

  typedef struct {
    row_kind_e         kind;
    logic [ADDR_W-1:0] addr;
    logic [CFG_W-1:0]  value;
    pixel_item_t       item;
    bit                typed;
    blend_res_t        want;
  } plan_row_t;

  localparam blend_res_t NOT_WRITTEN = '0;

  logic              clk;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  lsfb_in_if  in_bus ();
  lsfb_out_if out_bus ();

  linear_seam_feather_blend u_dut (
    .clk_i   (clk),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [CFG_W-1:0] cfg_start_raw;
  logic [CFG_W-1:0] cfg_width;
  blend_res_t       blend_fifo [$];
  blend_res_t       next_blend;
  int unsigned      send_idle_pct = 0;
  int unsigned      stall_pct     = 0;
  int unsigned      mismatches    = 0;
  int unsigned      quiet_cycles  = 0;
  bit               hold_rx       = 1'b0;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic lsfb_px_t rgb(logic [PIX_W-1:0] c0, logic [PIX_W-1:0] c1,
                                   logic [PIX_W-1:0] c2);
    return {c2, c1, c0};
  endfunction

  function automatic void overlap_bounds(output int unsigned lo, output int unsigned hi);
    lo = cfg_start_raw[CFG_W-1] ? 0 : int'(cfg_start_raw);
    hi = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width);
  endfunction

  function automatic blend_res_t predict_blend(pixel_item_t p);
    blend_res_t  r;
    int unsigned lo, hi, span, k, acc;
    r = '0;
    overlap_bounds(lo, hi);
    if (p.column < lo || p.column >= hi) return r;
    r.write_enable = 1'b1;
    if (p.second_px == '0) begin
      r.blend = p.first_px;
      return r;
    end
    span = hi - lo;
    k    = p.column - lo;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc = p.first_px[ch] * (span - k) + p.second_px[ch] * k;
      r.blend[ch] = PIX_W'(acc / span);
    end
    return r;
  endfunction

  function automatic plan_row_t pixel_row(int unsigned col, lsfb_px_t first_px,
                                          lsfb_px_t second_px, bit typed, blend_res_t want);
    plan_row_t row;
    row.kind  = ROW_PIXEL;
    row.addr  = '0;
    row.value = '0;
    row.item  = '{column: COL_W'(col), first_px: first_px, second_px: second_px};
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t write_row(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
    plan_row_t row;
    row       = pixel_row(0, '0, '0, 1'b0, NOT_WRITTEN);
    row.kind  = ROW_WRITE;
    row.addr  = addr;
    row.value = value;
    return row;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  task automatic push_pixel(pixel_item_t p, blend_res_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid = 1'b0;
      @(negedge clk);
    end
    in_bus.valid     = 1'b1;
    in_bus.column    = p.column;
    in_bus.first_c0  = p.first_px[0];
    in_bus.first_c1  = p.first_px[1];
    in_bus.first_c2  = p.first_px[2];
    in_bus.second_c0 = p.second_px[0];
    in_bus.second_c1 = p.second_px[1];
    in_bus.second_c2 = p.second_px[2];
    next_blend       = want;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  task automatic drain_pipeline();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (blend_fifo.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [ADDR_W-1:0] addr, logic [CFG_W-1:0] value);
    logic [DATA_W-CFG_W-1:0] junk;
    junk = (DATA_W-CFG_W)'($urandom());
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {junk, value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_OVERLAP_START) cfg_start_raw = value;
    else if (addr == ADDR_IMAGE_WIDTH) cfg_width = value;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[CFG_W-1:0] != value)
      report_mismatch("register readback", prdata[CFG_W-1:0], value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  always @(negedge clk) begin
    out_bus.ready = !hold_rx && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    blend_res_t want;
    lsfb_px_t   got_px;
    bit         quiet;
    if (rst_ni) begin
      quiet = 1'b1;
      if (out_bus.valid && out_bus.ready) begin
        quiet = 1'b0;
        if (blend_fifo.size() == 0) begin
          report_mismatch("item with nothing expected", 1, 0);
        end else begin
          want   = blend_fifo.pop_front();
          got_px = {out_bus.blend_c2, out_bus.blend_c1, out_bus.blend_c0};
          for (int ch = 0; ch < NUM_CH; ch++)
            if (got_px[ch] != want.blend[ch])
              report_mismatch($sformatf("blend_c%0d", ch), got_px[ch], want.blend[ch]);
          if (out_bus.write_enable != want.write_enable)
            report_mismatch("write_enable", out_bus.write_enable, want.write_enable);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        quiet = 1'b0;
        blend_fifo = {blend_fifo, next_blend};
      end
      quiet_cycles = quiet ? quiet_cycles + 1 : 0;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_linear_seam_feather_blend: FAIL");
        $finish;
      end
    end
  end

  initial begin
    plan_row_t        plan [$];
    pixel_item_t      p;
    logic [CFG_W-1:0] s_val, w_val;
    int unsigned      lo, hi, sel;

    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_bus.valid     = 1'b0;
    in_bus.column    = '0;
    in_bus.first_c0  = '0;
    in_bus.first_c1  = '0;
    in_bus.first_c2  = '0;
    in_bus.second_c0 = '0;
    in_bus.second_c1 = '0;
    in_bus.second_c2 = '0;
    out_bus.ready    = 1'b0;
    next_blend       = '0;
    cfg_start_raw    = '0;
    cfg_width        = CFG_W'(MAX_WIDTH);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_ni = 1'b1;

    // values after reset: start 0, width 4096
    plan = {plan, pixel_row(0, rgb(255, 255, 255), rgb(1, 2, 3), 1'b1,
                            '{rgb(255, 255, 255), 1'b1})};
    plan = {plan, pixel_row(0, rgb(0, 0, 0), rgb(255, 255, 255), 1'b1,
                            '{rgb(0, 0, 0), 1'b1})};
    plan = {plan, pixel_row(4095, rgb(255, 255, 255), rgb(255, 255, 255), 1'b1,
                            '{rgb(255, 255, 255), 1'b1})};
    plan = {plan, pixel_row(4095, rgb(0, 0, 0), rgb(255, 255, 255), 1'b1,
                            '{rgb(254, 254, 254), 1'b1})};
    plan = {plan, pixel_row(4095, rgb(255, 128, 1), rgb(0, 0, 0), 1'b1,
                            '{rgb(255, 128, 1), 1'b1})};
    plan = {plan, pixel_row(4095, rgb(0, 0, 0), rgb(0, 0, 1), 1'b1,
                            '{rgb(0, 0, 0), 1'b1})};
    plan = {plan, pixel_row(2048, rgb(10, 20, 30), rgb(250, 240, 230), 1'b0,
                            NOT_WRITTEN)};
    plan = {plan, pixel_row(1365, rgb(170, 85, 255), rgb(85, 170, 0), 1'b0,
                            NOT_WRITTEN)};
    // negative start clamps to zero
    plan = {plan, write_row(ADDR_OVERLAP_START, 13'h1FFF)};
    plan = {plan, write_row(ADDR_IMAGE_WIDTH, 13'd100)};
    plan = {plan, pixel_row(99, rgb(0, 0, 0), rgb(255, 255, 255), 1'b1,
                            '{rgb(252, 252, 252), 1'b1})};
    plan = {plan, pixel_row(100, rgb(255, 255, 255), rgb(255, 255, 255), 1'b1,
                            NOT_WRITTEN)};
    plan = {plan, pixel_row(50, rgb(200, 0, 17), rgb(0, 0, 0), 1'b1,
                            '{rgb(200, 0, 17), 1'b1})};
    plan = {plan, pixel_row(37, rgb(91, 3, 240), rgb(7, 199, 64), 1'b0, NOT_WRITTEN)};
    // widest start, oversized width saturates
    plan = {plan, write_row(ADDR_OVERLAP_START, 13'd4095)};
    plan = {plan, write_row(ADDR_IMAGE_WIDTH, 13'h1FFF)};
    plan = {plan, pixel_row(4095, rgb(1, 2, 3), rgb(255, 254, 253), 1'b1,
                            '{rgb(1, 2, 3), 1'b1})};
    plan = {plan, pixel_row(4094, rgb(1, 2, 3), rgb(255, 254, 253), 1'b1, NOT_WRITTEN)};
    plan = {plan, pixel_row(0, rgb(1, 2, 3), rgb(255, 254, 253), 1'b1, NOT_WRITTEN)};
    // empty overlap, width zero
    plan = {plan, write_row(ADDR_IMAGE_WIDTH, 13'd0)};
    plan = {plan, pixel_row(4095, rgb(9, 9, 9), rgb(9, 9, 9), 1'b1, NOT_WRITTEN)};
    plan = {plan, write_row(ADDR_OVERLAP_START, 13'h1000)};
    plan = {plan, pixel_row(0, rgb(9, 9, 9), rgb(9, 9, 9), 1'b1, NOT_WRITTEN)};
    plan = {plan, write_row(ADDR_IMAGE_WIDTH, 13'd1)};
    plan = {plan, pixel_row(0, rgb(9, 8, 7), rgb(200, 200, 200), 1'b1,
                            '{rgb(9, 8, 7), 1'b1})};
    plan = {plan, pixel_row(1, rgb(9, 8, 7), rgb(200, 200, 200), 1'b1, NOT_WRITTEN)};
    // width equal to start
    plan = {plan, write_row(ADDR_OVERLAP_START, 13'd2000)};
    plan = {plan, write_row(ADDR_IMAGE_WIDTH, 13'd2000)};
    plan = {plan, pixel_row(2000, rgb(50, 60, 70), rgb(80, 90, 100), 1'b1, NOT_WRITTEN)};
    plan = {plan, write_row(ADDR_IMAGE_WIDTH, 13'd4097)};
    plan = {plan, pixel_row(4095, rgb(0, 255, 100), rgb(255, 0, 200), 1'b0, NOT_WRITTEN)};
    plan = {plan, pixel_row(1999, rgb(0, 255, 100), rgb(255, 0, 200), 1'b1, NOT_WRITTEN)};

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain_pipeline();
        write_register(plan[i].addr, plan[i].value);
      end else begin
        push_pixel(plan[i].item,
                   plan[i].typed ? plan[i].want : predict_blend(plan[i].item));
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          s_val = '0;
          w_val = CFG_W'(MAX_WIDTH);
        end
        1: begin
          s_val = 13'h1000;
          w_val = 13'h1FFF;
        end
        2: begin
          s_val = 13'd4095;
          w_val = 13'd4096;
        end
        3: begin
          s_val = 13'd1000;
          w_val = 13'd1016;
        end
        4: begin
          s_val = CFG_W'($urandom_range(3000));
          w_val = CFG_W'($urandom_range(MAX_WIDTH, s_val + 1));
        end
        5: begin
          s_val = CFG_W'(0 - $urandom_range(4096, 1));
          w_val = CFG_W'($urandom_range(64, 1));
        end
        6: begin
          s_val = CFG_W'($urandom());
          w_val = CFG_W'($urandom());
        end
        default: begin
          s_val = 13'd2048;
          w_val = 13'd3000;
        end
      endcase
      drain_pipeline();
      write_register(ADDR_OVERLAP_START, s_val);
      write_register(ADDR_IMAGE_WIDTH, w_val);
      overlap_bounds(lo, hi);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 51;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 51;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct     = 32;
        end
      endcase
      // long receiver hold-off while the sender keeps offering
      if (ph == 4) begin
        fork
          begin
            @(posedge clk);
            hold_rx = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_rx = 1'b0;
          end
        join_none
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        sel = $urandom_range(99);
        if (hi > lo && sel < 70) begin
          p.column = COL_W'($urandom_range(hi - 1, lo));
        end else if (sel < 85) begin
          p.column = COL_W'($urandom());
        end else begin
          case ($urandom_range(3))
            0: p.column = COL_W'(lo);
            1: p.column = COL_W'(lo - 1);
            2: p.column = COL_W'(hi - 1);
            default: p.column = COL_W'(hi);
          endcase
        end
        p.first_px  = lsfb_px_t'($urandom());
        p.second_px = lsfb_px_t'($urandom());
        sel = $urandom_range(99);
        if (sel < 15) p.second_px = '0;
        else if (sel < 20) p.second_px = '1;
        else if (sel < 25) p.first_px = '1;
        else if (sel < 30) p.first_px = '0;
        push_pixel(p, predict_blend(p));
      end
    end

    drain_pipeline();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_linear_seam_feather_blend: PASS");
    end else begin
      $display("tb_linear_seam_feather_blend: FAIL");
    end
    $finish;
  end

endmodule
